/* src/m3inv_pkg.sv */
package m3inv_pkg;

  localparam int DW   = 32;
  localparam int FB   = 16;
  localparam int NE   = 9;
  localparam int THRW = 17;

  // Exact intermediate widths: products, adjugate, determinant.
  localparam int SH   = 2 * FB;
  localparam int PW   = 2 * DW;
  localparam int AW   = 2 * DW + 1;
  localparam int AMW  = 2 * DW;
  localparam int LOW  = DW + 1;
  localparam int HIW  = AW - LOW;
  localparam int PLW  = DW + LOW + 1;
  localparam int PHW  = DW + HIW;
  localparam int DETW = 3 * DW + 1;
  localparam int DMW  = 3 * DW;
  localparam int RQW  = DMW + 1 - SH;

  // Divider: numerator, denominator and quotient widths.
  localparam int NW   = ((AMW + SH > DMW) ? AMW + SH : DMW) + 2;
  localparam int DENW = DMW + 1;
  localparam int QW   = DW + 1;

  // Pipeline stages: front end, divider lanes plus their saturation, merge.
  localparam int FS = 6;
  localparam int LS = QW + 1;
  localparam int NS = FS + LS + 1;

  // Cofactor k is m[PA]*m[PB] - m[PC]*m[PD].
  localparam int PA [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PC [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PD [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic signed [DW-1:0] elem_t;
  typedef logic [NE-1:0][DW-1:0] mat_t;

  localparam elem_t ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    elem_t a00;
    elem_t a01;
    elem_t a02;
    elem_t a10;
    elem_t a11;
    elem_t a12;
    elem_t a20;
    elem_t a21;
    elem_t a22;
  } in_t;

  typedef struct packed {
    elem_t r00;
    elem_t r01;
    elem_t r02;
    elem_t r10;
    elem_t r11;
    elem_t r12;
    elem_t r20;
    elem_t r21;
    elem_t r22;
    elem_t det_value;
    logic  is_singular;
    logic  saturated;
  } out_t;

  typedef struct packed {
    mat_t  mat;
    logic  sing;
    elem_t det_val;
    logic  det_clip;
  } side_t;

  typedef struct packed {
    elem_t value;
    logic  clip;
  } lane_res_t;

endpackage

/* src/m3inv_stream_if.sv */
interface m3inv_in_if;
  logic              valid;
  logic              ready;
  m3inv_pkg::in_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m3inv_out_if;
  logic              valid;
  logic              ready;
  m3inv_pkg::out_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/m3inv_front.sv */
module m3inv_front (
  input  logic                           clk_i,
  input  logic [m3inv_pkg::FS-1:0]       load_i,
  input  m3inv_pkg::in_t                 in_data_i,
  input  logic [m3inv_pkg::THRW-1:0]     thr_i,
  output logic [m3inv_pkg::NW-1:0]       n_o [m3inv_pkg::NE],
  output logic [m3inv_pkg::DENW-1:0]     den_o,
  output logic                           neg_o [m3inv_pkg::NE],
  output m3inv_pkg::side_t               side_o
);

  localparam logic [m3inv_pkg::DMW:0] RND =
    (m3inv_pkg::DMW + 1)'(1) << (m3inv_pkg::SH - 1);
  localparam logic [m3inv_pkg::RQW-1:0] POS_LIM =
    {{(m3inv_pkg::RQW - m3inv_pkg::DW + 1){1'b0}}, {(m3inv_pkg::DW - 1){1'b1}}};
  localparam logic [m3inv_pkg::RQW-1:0] NEG_LIM = POS_LIM + 1'b1;

  m3inv_pkg::mat_t m0_q, m1_q, m2_q, m3_q, m4_q;
  logic signed [m3inv_pkg::PW-1:0]   p_q    [2*m3inv_pkg::NE];
  logic signed [m3inv_pkg::AW-1:0]   adj_q  [m3inv_pkg::NE];
  logic signed [m3inv_pkg::AW-1:0]   adj3_q [m3inv_pkg::NE];
  logic signed [m3inv_pkg::AW-1:0]   adj4_q [m3inv_pkg::NE];
  logic signed [m3inv_pkg::PLW-1:0]  plo_q  [3];
  logic signed [m3inv_pkg::PHW-1:0]  phi_q  [3];
  logic signed [m3inv_pkg::DETW-1:0] det_q, det_d;

  logic [m3inv_pkg::NW-1:0]   n_d [m3inv_pkg::NE];
  logic                       neg_d [m3inv_pkg::NE];
  logic [m3inv_pkg::NW-1:0]   n_q [m3inv_pkg::NE];
  logic                       neg_q [m3inv_pkg::NE];
  logic [m3inv_pkg::DENW-1:0] den_q;
  m3inv_pkg::side_t           side_q, side_d;

  logic [m3inv_pkg::DETW-1:0] det_mag;
  logic [m3inv_pkg::DMW-1:0]  abs_det;
  logic [m3inv_pkg::DMW:0]    rq_full;
  logic [m3inv_pkg::RQW-1:0]  rq;
  logic                       det_neg;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      m0_q <= {in_data_i.a22, in_data_i.a21, in_data_i.a20,
               in_data_i.a12, in_data_i.a11, in_data_i.a10,
               in_data_i.a02, in_data_i.a01, in_data_i.a00};
    end
    if (load_i[1]) begin
      m1_q <= m0_q;
      for (int i = 0; i < m3inv_pkg::NE; i++) begin
        p_q[2*i]   <= $signed(m0_q[m3inv_pkg::PA[i]]) * $signed(m0_q[m3inv_pkg::PB[i]]);
        p_q[2*i+1] <= $signed(m0_q[m3inv_pkg::PC[i]]) * $signed(m0_q[m3inv_pkg::PD[i]]);
      end
    end
    if (load_i[2]) begin
      m2_q <= m1_q;
      for (int i = 0; i < m3inv_pkg::NE; i++) begin
        adj_q[i] <= m3inv_pkg::AW'(p_q[2*i]) - m3inv_pkg::AW'(p_q[2*i+1]);
      end
    end
    // The 65-bit cofactors are split into a 33-bit unsigned low part and a
    // signed high part so that each first-row product stays near 32x32.
    if (load_i[3]) begin
      m3_q   <= m2_q;
      adj3_q <= adj_q;
      for (int r = 0; r < 3; r++) begin
        plo_q[r] <= $signed(m2_q[r]) *
                    $signed({1'b0, adj_q[3*r][m3inv_pkg::LOW-1:0]});
        phi_q[r] <= $signed(m2_q[r]) *
                    $signed(adj_q[3*r][m3inv_pkg::AW-1:m3inv_pkg::LOW]);
      end
    end
    if (load_i[4]) begin
      m4_q   <= m3_q;
      adj4_q <= adj3_q;
      det_q  <= det_d;
    end
    if (load_i[5]) begin
      n_q    <= n_d;
      neg_q  <= neg_d;
      den_q  <= m3inv_pkg::DENW'({abs_det, 1'b0});
      side_q <= side_d;
    end
  end

  always_comb begin
    det_d = '0;
    for (int r = 0; r < 3; r++) begin
      det_d = det_d + (m3inv_pkg::DETW'(phi_q[r]) <<< m3inv_pkg::LOW)
                    + m3inv_pkg::DETW'(plo_q[r]);
    end
  end

  always_comb begin
    logic [m3inv_pkg::AW-1:0] adj_mag;
    det_neg = det_q[m3inv_pkg::DETW-1];
    det_mag = det_neg ? -det_q : det_q;
    abs_det = det_mag[m3inv_pkg::DMW-1:0];
    rq_full = {1'b0, abs_det} + RND;
    rq      = rq_full[m3inv_pkg::DMW:m3inv_pkg::SH];

    side_d.mat  = m4_q;
    side_d.sing = abs_det <= m3inv_pkg::DMW'({thr_i, {m3inv_pkg::SH{1'b0}}});
    if (det_neg) begin
      side_d.det_clip = rq > NEG_LIM;
      side_d.det_val  = side_d.det_clip ? m3inv_pkg::ELEM_MIN : -rq[m3inv_pkg::DW-1:0];
    end else begin
      side_d.det_clip = rq > POS_LIM;
      side_d.det_val  = side_d.det_clip ? m3inv_pkg::ELEM_MAX : rq[m3inv_pkg::DW-1:0];
    end

    // Rounded quotient is floor((2|adj|*2^SH + |det|) / (2|det|)).
    for (int i = 0; i < m3inv_pkg::NE; i++) begin
      adj_mag  = adj4_q[i][m3inv_pkg::AW-1] ? -adj4_q[i] : adj4_q[i];
      n_d[i]   = (m3inv_pkg::NW'(adj_mag[m3inv_pkg::AMW-1:0]) << (m3inv_pkg::SH + 1))
               + m3inv_pkg::NW'(abs_det);
      neg_d[i] = adj4_q[i][m3inv_pkg::AW-1] ^ det_neg;
    end
  end

  assign n_o    = n_q;
  assign neg_o  = neg_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

/* src/m3inv_div_lane.sv */
module m3inv_div_lane (
  input  logic                       clk_i,
  input  logic [m3inv_pkg::LS-1:0]   load_i,
  input  logic [m3inv_pkg::NW-1:0]   n_i,
  input  logic [m3inv_pkg::DENW-1:0] den_i,
  input  logic                       neg_i,
  output m3inv_pkg::lane_res_t       res_o
);

  localparam int QW = m3inv_pkg::QW;
  localparam int NW = m3inv_pkg::NW;
  localparam logic [QW-1:0] POSQ = {2'b00, {(m3inv_pkg::DW - 1){1'b1}}};
  localparam logic [QW-1:0] NEGQ = {2'b01, {(m3inv_pkg::DW - 1){1'b0}}};

  logic [NW-1:0]              rem_q [QW-1];
  logic [m3inv_pkg::DENW-1:0] den_q [QW-1];
  logic [QW-1:0]              q_q   [QW];
  logic                       neg_q [QW];
  logic                       ovf_q [QW];
  m3inv_pkg::lane_res_t       res_q, res_d;

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [NW-1:0]              rem_in;
    logic [m3inv_pkg::DENW-1:0] den_in;
    logic [QW-1:0]              q_in, q_nx;
    logic                       neg_in, ovf_in, ge;

    if (j == 0) begin : g_first
      assign rem_in = n_i;
      assign den_in = den_i;
      assign q_in   = '0;
      assign neg_in = neg_i;
      // A quotient of 2^QW or more saturates whatever its sign.
      assign ovf_in = NW'(n_i[NW-1:QW]) >= NW'(den_i);
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign q_in   = q_q[j-1];
      assign neg_in = neg_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign ge = NW'(rem_in[NW-1:K]) >= NW'(den_in);

    always_comb begin
      q_nx    = q_in;
      q_nx[K] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (load_i[j]) begin
        q_q[j]   <= q_nx;
        neg_q[j] <= neg_in;
        ovf_q[j] <= ovf_in;
      end
    end

    if (j < QW - 1) begin : g_rem
      logic [NW-1:0] rem_nx;
      always_comb begin
        rem_nx = rem_in;
        if (ge) begin
          rem_nx[NW-1:K] = rem_in[NW-1:K] - (NW-K)'(den_in);
        end
      end
      always_ff @(posedge clk_i) begin
        if (load_i[j]) begin
          rem_q[j] <= rem_nx;
          den_q[j] <= den_in;
        end
      end
    end
  end

  always_comb begin
    logic [QW-1:0] q;
    q = q_q[QW-1];
    if (neg_q[QW-1]) begin
      res_d.clip  = ovf_q[QW-1] || (q > NEGQ);
      res_d.value = res_d.clip ? m3inv_pkg::ELEM_MIN : -q[m3inv_pkg::DW-1:0];
    end else begin
      res_d.clip  = ovf_q[QW-1] || (q > POSQ);
      res_d.value = res_d.clip ? m3inv_pkg::ELEM_MAX : q[m3inv_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[QW]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* src/m3inv_merge.sv */
module m3inv_merge (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  m3inv_pkg::lane_res_t res_i [m3inv_pkg::NE],
  input  m3inv_pkg::side_t     side_i,
  output m3inv_pkg::out_t      data_o
);

  m3inv_pkg::out_t data_q, data_d;

  always_comb begin
    m3inv_pkg::mat_t r;
    logic            any_clip;
    any_clip = 1'b0;
    for (int i = 0; i < m3inv_pkg::NE; i++) begin
      r[i]     = side_i.sing ? side_i.mat[i] : res_i[i].value;
      any_clip = any_clip | res_i[i].clip;
    end
    data_d.r00         = r[0];
    data_d.r01         = r[1];
    data_d.r02         = r[2];
    data_d.r10         = r[3];
    data_d.r11         = r[4];
    data_d.r12         = r[5];
    data_d.r20         = r[6];
    data_d.r21         = r[7];
    data_d.r22         = r[8];
    data_d.det_value   = side_i.det_val;
    data_d.is_singular = side_i.sing;
    // A singular matrix passes through, so only the determinant can clip.
    data_d.saturated   = side_i.det_clip | (~side_i.sing & any_clip);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

/* src/matrix3x3_inverse_top.sv */
// Throughput: one matrix per cycle while the output is not stalled; each stage holds until its successor has room,
// and the 33 one-bit divider stages in each of the nine lanes set the depth.
// Reset: rst_ni clears all stage valid flags and sets singular_threshold to 1;
// the datapath registers are not reset.
module matrix3x3_inverse_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [m3inv_pkg::THRW-1:0]     cfg_data_i,
  m3inv_in_if.sink                       in_i,
  m3inv_out_if.source                    out_o
);

  localparam int NS = m3inv_pkg::NS;
  localparam int FS = m3inv_pkg::FS;
  localparam int LS = m3inv_pkg::LS;

  logic [m3inv_pkg::THRW-1:0] thr_q;
  logic [NS-1:0]              v_q;
  logic [NS-1:0]              load;

  logic [m3inv_pkg::NW-1:0]   n_w [m3inv_pkg::NE];
  logic                       neg_w [m3inv_pkg::NE];
  logic [m3inv_pkg::DENW-1:0] den_w;
  m3inv_pkg::side_t           side_w;
  m3inv_pkg::side_t           side_q [LS];
  m3inv_pkg::lane_res_t       res_w [m3inv_pkg::NE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= m3inv_pkg::THRW'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // A stage takes new content when it is empty or its own content moves on.
  always_comb begin
    load[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      load[s] = !v_q[s] || load[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (load[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign in_i.ready  = load[0];
  assign out_o.valid = v_q[NS-1];

  m3inv_front u_front (
    .clk_i     (clk_i),
    .load_i    (load[FS-1:0]),
    .in_data_i (in_i.data),
    .thr_i     (thr_q),
    .n_o       (n_w),
    .den_o     (den_w),
    .neg_o     (neg_w),
    .side_o    (side_w)
  );

  for (genvar i = 0; i < m3inv_pkg::NE; i++) begin : g_lane
    m3inv_div_lane u_lane (
      .clk_i  (clk_i),
      .load_i (load[FS+LS-1:FS]),
      .n_i    (n_w[i]),
      .den_i  (den_w),
      .neg_i  (neg_w[i]),
      .res_o  (res_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (load[FS]) begin
      side_q[0] <= side_w;
    end
    for (int j = 1; j < LS; j++) begin
      if (load[FS+j]) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  m3inv_merge u_merge (
    .clk_i  (clk_i),
    .load_i (load[NS-1]),
    .res_i  (res_w),
    .side_i (side_q[LS-1]),
    .data_o (out_o.data)
  );

endmodule
